FILE: rtl/core/cleb_pkg.sv
// Shared constants for the cursor line edit buffer.
// Holds the line depth, derived widths and the decoded key codes; no dependencies.
package cleb_pkg;

  localparam int LINE_DEPTH = 64;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int CNT_W      = ADDR_W + 1;

  localparam logic [7:0] KEY_LEFT  = 8'h3C;
  localparam logic [7:0] KEY_RIGHT = 8'h3E;
  localparam logic [7:0] KEY_DEL   = 8'h2D;

endpackage

FILE: rtl/core/cleb_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Read data is registered: it appears in the cycle after a read enable and holds until the next read.
module cleb_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/cursor_line_edit_buffer_top.sv
// Top level of the cursor line edit buffer: decode, gap buffer control and output register.
// Depends on cleb_pkg and cleb_ram.
//
// Usage: key words enter on the in_ channel. With in_tuser low, in_tdata is a keystroke:
// '<' and '>' move the cursor, '-' deletes before it, any other byte is inserted at it.
// With in_tuser high the word ends the line: its characters leave on the out_ channel in
// order, the final one with out_tlast high, and the line is cleared. An empty line gives
// one word with out_tdata zero and out_tuser[0] (empty) high. out_tuser[1] copies the
// sticky overflow flag, set when an insert finds the line store full.
// Sequence: an insert, a delete or an ignored key is handled in ST_IDLE; a cursor move reads
// the gap buffer memory in ST_IDLE, then writes the character back in ST_MOVE. Ending a line
// reads each character from the memory in ST_RD and then loads it into the output register
// in ST_LD, waiting while the output register is full; an empty line gives its word from
// ST_EMPTY. in_tready is low while a move or a line emission is under way.
// Reset clears the cursor counts, the overflow flag and the output valid flag; the line
// store itself is not cleared. When the receiver stalls, the output register holds its
// word and emission pauses; keystrokes are still taken while a final word waits.
module cursor_line_edit_buffer_top
  import cleb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] key_byte
  input  logic       in_tuser,   // [0] func
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast,
  output logic [1:0] out_tuser   // [0] empty_res, [1] overflowed
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOVE,
    ST_RD,
    ST_LD,
    ST_EMPTY
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic [CNT_W-1:0]  right_r, right_nxt;
  logic              ovf_r, ovf_nxt;
  logic [ADDR_W-1:0] dst_r, dst_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [CNT_W-1:0]  gap_r, gap_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_empty_r, out_empty_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  logic [CNT_W-1:0]  sum;
  logic [CNT_W-1:0]  rd_idx;
  logic              out_free;
  logic              is_last;

  cleb_ram #(
    .DATA_W(8),
    .DEPTH (LINE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_ovf_r, out_empty_r};

  assign sum      = left_r + right_r;
  assign out_free = !out_valid_r || out_tready;
  assign rd_idx   = (idx_r < left_r) ? idx_r : idx_r + gap_r;
  assign is_last  = ((idx_r + CNT_W'(1)) == total_r);

  always_comb begin
    state_nxt     = state_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    ovf_nxt       = ovf_r;
    dst_nxt       = dst_r;
    idx_nxt       = idx_r;
    total_nxt     = total_r;
    gap_nxt       = gap_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    out_ovf_nxt   = out_ovf_r;
    ram_we        = 1'b0;
    ram_waddr     = left_r[ADDR_W-1:0];
    ram_wdata     = in_tdata;
    ram_re        = 1'b0;
    ram_raddr     = rd_idx[ADDR_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser) begin
            if (sum == '0) begin
              state_nxt = ST_EMPTY;
            end else begin
              total_nxt = sum;
              gap_nxt   = CNT_W'(LINE_DEPTH) - sum;
              idx_nxt   = '0;
              state_nxt = ST_RD;
            end
          end else if (in_tdata == KEY_LEFT) begin
            if (left_r != '0) begin
              ram_re    = 1'b1;
              ram_raddr = ADDR_W'(left_r - CNT_W'(1));
              dst_nxt   = ADDR_W'(CNT_W'(LINE_DEPTH - 1) - right_r);
              left_nxt  = left_r - CNT_W'(1);
              right_nxt = right_r + CNT_W'(1);
              state_nxt = ST_MOVE;
            end
          end else if (in_tdata == KEY_RIGHT) begin
            if (right_r != '0) begin
              ram_re    = 1'b1;
              ram_raddr = ADDR_W'(CNT_W'(LINE_DEPTH) - right_r);
              dst_nxt   = left_r[ADDR_W-1:0];
              left_nxt  = left_r + CNT_W'(1);
              right_nxt = right_r - CNT_W'(1);
              state_nxt = ST_MOVE;
            end
          end else if (in_tdata == KEY_DEL) begin
            if (left_r != '0) begin
              left_nxt = left_r - CNT_W'(1);
            end
          end else begin
            if (sum < CNT_W'(LINE_DEPTH)) begin
              ram_we   = 1'b1;
              left_nxt = left_r + CNT_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
      end
      ST_MOVE: begin
        ram_we    = 1'b1;
        ram_waddr = dst_r;
        ram_wdata = ram_rdata;
        state_nxt = ST_IDLE;
      end
      ST_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_LD;
      end
      ST_LD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ram_rdata;
          out_last_nxt  = is_last;
          out_empty_nxt = 1'b0;
          out_ovf_nxt   = ovf_r;
          if (is_last) begin
            left_nxt  = '0;
            right_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = ST_RD;
          end
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_empty_nxt = 1'b1;
          out_ovf_nxt   = ovf_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      left_r      <= '0;
      right_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dst_r       <= dst_nxt;
    idx_r       <= idx_nxt;
    total_r     <= total_nxt;
    gap_r       <= gap_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

endmodule
